### rtl/cst_pkg.sv
// Package for the context slot table: table geometry, payload structs,
// command codes and register indexes.
// Depends on nothing.
package cst_pkg;

  localparam int TABLE_BITS = 12;
  localparam int WAYS = 4;

  localparam int CmdW = 3;
  localparam int BucketW = 10;
  localparam int TagW = 16;
  localparam int SlotW = 12;
  localparam int ProbW = 16;
  localparam int CountW = 16;
  localparam int CfgIdxW = 1;

  localparam logic [CmdW-1:0] CMD_LOOKUP = 3'd0;
  localparam logic [CmdW-1:0] CMD_CLAIM = 3'd1;
  localparam logic [CmdW-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CmdW-1:0] CMD_PROMOTE = 3'd3;
  localparam logic [CmdW-1:0] CMD_HALVE = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_COUNT_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_INIT_PROB = 1'd1;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [BucketW-1:0] bucket;
    logic [TagW-1:0] tag;
    logic [SlotW-1:0] slot_index;
    logic bit_req;
  } cst_in_t;

  typedef struct packed {
    logic found;
    logic [SlotW-1:0] slot_out;
    logic [ProbW-1:0] probability;
  } cst_out_t;

endpackage

### rtl/context_slot_table.sv
// Top level of the context slot table: configuration registers, the
// command front end and the slot back end. Depends on cst_pkg,
// cst_front and cst_back.
//
//  channel   direction  handshake             beat
//  command   in         start & !busy         cmd (cst_in_t)
//  config    in         cfg_valid & cfg_ready cfg_index, cfg_data
//  result    out        done, one cycle       result (cst_out_t)
//
// Lookup and claim scan the ways of the bucket; update reads the slot and
// runs a bit-serial division that forms the rate; promote checks the
// witness; halve sweeps all slots; an unknown command returns an empty
// result. A beat accepted while the back end is idle still passes through
// the queue. After reset a clearing pass over all 2^TABLE_BITS slots runs
// with busy high. The front queue holds two beats so commands can arrive
// while the back end works; results cannot be stalled.
module context_slot_table import cst_pkg::*; #(
  parameter int RATE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cst_in_t            cmd,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output cst_out_t           result
);

  logic [CountW-1:0] count_limit;
  logic [ProbW-1:0] initial_probability;
  logic full, avail, pop, clearing;
  cst_in_t head;

  assign cfg_ready = 1'b1;
  // Busy while the queue is full or the memories are still being cleared.
  assign busy = full | clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= 16'd255;
      initial_probability <= 16'd32768;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COUNT_LIMIT: count_limit <= cfg_data;
        REG_INIT_PROB: initial_probability <= cfg_data;
        default: ;
      endcase
    end
  end

  cst_front u_front (
    .clk, .rst, .push(start & ~busy), .push_data(cmd), .full,
    .pop, .avail, .head
  );

  cst_back #(.RATE_ENTRIES(RATE_ENTRIES)) u_back (
    .clk, .rst, .avail, .head, .pop, .count_limit, .initial_probability,
    .res_valid(done), .res(result), .clearing
  );

endmodule

### rtl/cst_front.sv
// Front end of the context slot table: accepts command beats, folds the
// bucket and masks the slot index, and pushes them into a small queue.
// Depends on cst_pkg.
module cst_front import cst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cst_in_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    avail,
  output cst_in_t head
);

  localparam int NBuckets = (1 << TABLE_BITS) / WAYS;
  localparam int Depth = 2;

  cst_in_t q [Depth];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  cst_in_t norm;

  always_comb begin
    norm = push_data;
    // Bucket count is a power of two, so modulo is a mask.
    norm.bucket = push_data.bucket & BucketW'(NBuckets - 1);
    norm.slot_index = push_data.slot_index & SlotW'((1 << TABLE_BITS) - 1);
  end

  assign full = (cnt == 2'(Depth));
  assign avail = (cnt != 2'd0);
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        q[wr_ptr] <= norm;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/cst_back.sv
// Back end of the context slot table: slot memories, witness memory,
// clearing pass, halve sweep, rate division and per-command sequencing.
// Depends on cst_pkg.
module cst_back import cst_pkg::*; #(
  parameter int RATE_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  cst_in_t           head,
  output logic              pop,
  input  logic [CountW-1:0] count_limit,
  input  logic [ProbW-1:0]  initial_probability,
  output logic              res_valid,
  output cst_out_t          res,
  output logic              clearing
);

  localparam int NSlots = 1 << TABLE_BITS;
  localparam int NBuckets = NSlots / WAYS;
  localparam int WayCW = $clog2(WAYS + 1);
  localparam int BkW = (NBuckets > 1) ? $clog2(NBuckets) : 1;
  localparam int RateW = $clog2(RATE_ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN, S_UPD_RD, S_UPD, S_DIV, S_WIT_RD, S_WIT,
    S_HALVE_RD, S_HALVE, S_DONE
  } state_t;

  state_t state;

  logic [TagW-1:0]   tags  [NSlots];
  logic [CountW-1:0] cnts  [NSlots];
  logic [ProbW-1:0]  probs [NSlots];
  logic [TagW-1:0]   wits  [NBuckets];

  logic [TABLE_BITS-1:0] addr, ptr;
  logic [TagW-1:0]   rd_tag;
  logic [CountW-1:0] rd_cnt;
  logic [ProbW-1:0]  rd_prob;
  logic [TagW-1:0]   rd_wit;
  cst_in_t cur;
  logic [WayCW-1:0] way;
  logic [TABLE_BITS-1:0] victim;
  logic [CountW-1:0] victim_cnt;
  logic [RateW-1:0] ncap;
  logic signed [17:0] diff;
  logic signed [34:0] prod;
  logic signed [18:0] pnew;
  logic [ProbW-1:0] rate_r;
  logic [12:0] div_d, div_rem, rem_sh;
  logic [4:0] div_i;

  assign pop = (state == S_IDLE) && avail;
  assign clearing = (state == S_CLEAR);

  always_comb begin
    addr = ptr;
    if (state == S_IDLE) addr = head.slot_index[TABLE_BITS-1:0];
  end

  always_comb begin
    ncap = (rd_cnt > CountW'(RATE_ENTRIES - 1)) ? RateW'(RATE_ENTRIES - 1)
                                                : rd_cnt[RateW-1:0];
    // The dividend 131072 has its only set bit at the first step.
    rem_sh = {div_rem[11:0], div_i == 5'd0};
    diff = (cur.bit_req ? 18'sd65535 : 18'sd0) - $signed({2'b0, rd_prob});
    prod = 35'(diff) * $signed({19'b0, rate_r});
    // Arithmetic shift floors toward minus infinity.
    pnew = $signed({3'b0, rd_prob}) + 19'(prod >>> 16);
  end

  always_ff @(posedge clk) begin
    rd_tag <= tags[addr];
    rd_cnt <= cnts[addr];
    rd_prob <= probs[addr];
    rd_wit <= wits[cur.bucket[BkW-1:0]];
    res_valid <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          tags[ptr] <= '0;
          cnts[ptr] <= '0;
          probs[ptr] <= 16'd32768;
          if (ptr < TABLE_BITS'(NBuckets)) wits[ptr[BkW-1:0]] <= '0;
          ptr <= ptr + 1'b1;
          if (ptr == TABLE_BITS'(NSlots - 1)) state <= S_IDLE;
        end
        S_IDLE: if (avail) begin
          cur <= head;
          way <= '0;
          ptr <= TABLE_BITS'(head.bucket[BkW-1:0]) * TABLE_BITS'(WAYS);
          victim <= TABLE_BITS'(head.bucket[BkW-1:0]) * TABLE_BITS'(WAYS);
          victim_cnt <= '1;
          res <= '0;
          unique case (head.cmd)
            CMD_LOOKUP, CMD_CLAIM: state <= S_SCAN_RD;
            CMD_UPDATE: begin
              ptr <= head.slot_index[TABLE_BITS-1:0];
              state <= S_UPD_RD;
            end
            CMD_PROMOTE: state <= S_WIT_RD;
            CMD_HALVE: begin
              ptr <= '0;
              state <= S_HALVE_RD;
            end
            default: state <= S_DONE;
          endcase
        end
        S_SCAN_RD: state <= S_SCAN;
        S_SCAN: begin
          if (rd_tag == cur.tag) begin
            res.slot_out <= SlotW'(ptr);
            res.probability <= rd_prob;
            res.found <= (cur.cmd == CMD_LOOKUP);
            state <= S_DONE;
          end else if (cur.cmd == CMD_CLAIM &&
                       (rd_tag == '0 || way == WayCW'(WAYS - 1))) begin
            logic [TABLE_BITS-1:0] v;
            v = (rd_tag == '0 || rd_cnt < victim_cnt) ? ptr : victim;
            tags[v] <= cur.tag;
            cnts[v] <= '0;
            probs[v] <= initial_probability;
            res.slot_out <= SlotW'(v);
            res.probability <= initial_probability;
            state <= S_DONE;
          end else if (way == WayCW'(WAYS - 1)) begin
            state <= S_DONE;
          end else begin
            if (rd_cnt < victim_cnt) begin
              victim <= ptr;
              victim_cnt <= rd_cnt;
            end
            way <= way + 1'b1;
            ptr <= ptr + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_UPD_RD: state <= S_UPD;
        S_UPD: begin
          // The rate divisor is 2n + 3; the quotient is built one bit a cycle.
          div_d <= 13'({ncap, 1'b1}) + 13'd2;
          div_rem <= '0;
          div_i <= '0;
          rate_r <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= div_d) begin
            div_rem <= rem_sh - div_d;
            rate_r <= {rate_r[ProbW-2:0], 1'b1};
          end else begin
            div_rem <= rem_sh;
            rate_r <= {rate_r[ProbW-2:0], 1'b0};
          end
          div_i <= div_i + 5'd1;
          if (div_i == 5'd17) state <= S_WIT;
        end
        S_WIT_RD: state <= S_WIT;
        S_WIT: begin
          if (cur.cmd == CMD_UPDATE) begin
            logic [ProbW-1:0] pc;
            pc = (pnew < 19'sd1) ? 16'd1 : (pnew > 19'sd65535) ? 16'd65535
                                 : pnew[15:0];
            probs[ptr] <= pc;
            if (rd_cnt < count_limit) cnts[ptr] <= rd_cnt + 1'b1;
            res.probability <= pc;
          end else if (rd_wit == cur.tag) begin
            wits[cur.bucket[BkW-1:0]] <= '0;
            res.found <= 1'b1;
          end else begin
            wits[cur.bucket[BkW-1:0]] <= cur.tag;
          end
          state <= S_DONE;
        end
        S_HALVE_RD: state <= S_HALVE;
        S_HALVE: begin
          if (rd_cnt > 16'd1) cnts[ptr] <= rd_cnt >> 1;
          ptr <= ptr + 1'b1;
          state <= (ptr == TABLE_BITS'(NSlots - 1)) ? S_DONE : S_HALVE_RD;
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
